/* rtl/dwpr_pkg.sv */
// Package with the request, result and cell control types of the deque.
`default_nettype none
package dwpr_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE_AT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam int unsigned PosW  = 11;
  localparam int unsigned WordW = 32;

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [WordW-1:0] value;
    logic [PosW-1:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [WordW-1:0] removed_value;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic remove;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/deque_with_positional_remove.sv */
// Top level of the bounded deque with pushes, pops and positional removal.
// The deque holds up to DEPTH signed words in a row of cells, front first. Every request
// is handled in the cycle it is accepted and its result appears in the output register on
// the next cycle, so with out_ready held high one request is taken every cycle. A front
// push shifts every cell, a pop or removal shifts those behind it, and a back push fills
// the first free cell. The removed word is picked from the row by a select that spans
// all cells. A push to a full deque is dropped with status full; a pop or removal on an
// empty deque reports empty; a removal at position zero or past the last entry reports
// an invalid position. Unused operation codes change nothing and return status ok.
`default_nettype none
module deque_with_positional_remove #(
  parameter int unsigned DEPTH = 16
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  dwpr_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output dwpr_pkg::out_t  out_data
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  logic                     accept;
  logic [CntW-1:0]          count_r;
  logic [CntW-1:0]          count_nxt;
  logic                     out_valid_r;
  dwpr_pkg::out_t           out_data_r;
  dwpr_pkg::out_t           result;
  dwpr_pkg::cell_ctrl_t     ctrl;
  logic [IdxW-1:0]          idx;
  logic                     is_full;
  logic                     is_empty;
  logic [dwpr_pkg::PosW-1:0] count_ext;
  logic signed [dwpr_pkg::WordW-1:0] picked;
  logic signed [dwpr_pkg::WordW-1:0] cell_data [DEPTH];
  logic signed [dwpr_pkg::WordW-1:0] cell_hit  [DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count_r == CntW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign count_ext = dwpr_pkg::PosW'(count_r);

  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | cell_hit[i];
    end
  end

  always_comb begin
    ctrl                 = '0;
    idx                  = '0;
    count_nxt            = count_r;
    result.removed_value = '0;
    result.status        = dwpr_pkg::ST_OK;
    case (in_data.operation)
      dwpr_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          result.status = dwpr_pkg::ST_FULL;
        end else begin
          ctrl.push_front = 1'b1;
          count_nxt       = count_r + CntW'(1);
        end
      end
      dwpr_pkg::OP_PUSH_BACK: begin
        idx = IdxW'(count_r);
        if (is_full) begin
          result.status = dwpr_pkg::ST_FULL;
        end else begin
          ctrl.push_back = 1'b1;
          count_nxt      = count_r + CntW'(1);
        end
      end
      dwpr_pkg::OP_POP_FRONT: begin
        idx = '0;
        if (is_empty) begin
          result.status = dwpr_pkg::ST_EMPTY;
        end else begin
          ctrl.remove          = 1'b1;
          result.removed_value = picked;
          count_nxt            = count_r - CntW'(1);
        end
      end
      dwpr_pkg::OP_POP_BACK: begin
        idx = IdxW'(count_r - CntW'(1));
        if (is_empty) begin
          result.status = dwpr_pkg::ST_EMPTY;
        end else begin
          ctrl.remove          = 1'b1;
          result.removed_value = picked;
          count_nxt            = count_r - CntW'(1);
        end
      end
      dwpr_pkg::OP_REMOVE_AT: begin
        idx = IdxW'(in_data.position - dwpr_pkg::PosW'(1));
        if (is_empty) begin
          result.status = dwpr_pkg::ST_EMPTY;
        end else if (in_data.position == '0 || in_data.position > count_ext) begin
          result.status = dwpr_pkg::ST_BADPOS;
        end else begin
          ctrl.remove          = 1'b1;
          result.removed_value = picked;
          count_nxt            = count_r - CntW'(1);
        end
      end
      default: begin
        result.status = dwpr_pkg::ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [dwpr_pkg::WordW-1:0] prev_w;
    logic signed [dwpr_pkg::WordW-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = in_data.value;
    end else begin : g_mid
      assign prev_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cell_data[g];
    end else begin : g_body
      assign next_w = cell_data[g+1];
    end
    dwpr_cell #(
      .IdxW  (IdxW),
      .Index (g)
    ) u_cell (
      .clk       (clk),
      .en        (accept),
      .ctrl      (ctrl),
      .idx       (idx),
      .value     (in_data.value),
      .prev_data (prev_w),
      .next_data (next_w),
      .data_o    (cell_data[g]),
      .hit_o     (cell_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request gave no result");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_full && (in_data.operation == dwpr_pkg::OP_PUSH_FRONT ||
      in_data.operation == dwpr_pkg::OP_PUSH_BACK)
    |=> out_data_r.status == dwpr_pkg::ST_FULL && $stable(count_r))
    else $error("push on full deque not rejected");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != dwpr_pkg::ST_OK |-> out_data_r.removed_value == '0)
    else $error("error result carries a word");

endmodule
`default_nettype wire

/* rtl/dwpr_cell.sv */
// One storage cell of the deque chain; it shifts with its neighbors.
`default_nettype none
module dwpr_cell #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  wire                              clk,
  input  wire                              en,
  input  dwpr_pkg::cell_ctrl_t             ctrl,
  input  wire [IdxW-1:0]                   idx,
  input  wire signed [dwpr_pkg::WordW-1:0] value,
  input  wire signed [dwpr_pkg::WordW-1:0] prev_data,
  input  wire signed [dwpr_pkg::WordW-1:0] next_data,
  output logic signed [dwpr_pkg::WordW-1:0] data_o,
  output logic signed [dwpr_pkg::WordW-1:0] hit_o
);

  logic signed [dwpr_pkg::WordW-1:0] data_r;
  logic signed [dwpr_pkg::WordW-1:0] data_nxt;
  logic [IdxW-1:0]                   my_idx;

  assign my_idx = IdxW'(Index);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_front) begin
      data_nxt = prev_data;
    end else if (ctrl.push_back) begin
      if (idx == my_idx) begin
        data_nxt = value;
      end
    end else if (ctrl.remove) begin
      if (my_idx >= idx) begin
        data_nxt = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;
  assign hit_o  = (idx == my_idx) ? data_r : '0;

endmodule
`default_nettype wire
